// ----- hw/rtl/bpfa_pkg.sv -----
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

   localparam int PAGE_W     = 12;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int MANAGED_W  = 13;
   localparam int RESERVED_W = 12;
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 1;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MANAGED  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'b1;

   localparam logic [MANAGED_W-1:0]  MANAGED_RESET  = 13'd4096;
   localparam logic [RESERVED_W-1:0] RESERVED_RESET = 12'd1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]   page_out;
      logic [STATUS_W-1:0] status;
      logic                in_use;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOK
   } state_type;

endpackage

// ----- hw/rtl/bitmap_page_frame_allocator.sv -----
// Top level of the bitmap page frame allocator: sequencer, word scanner and config registers.
//
//   channel   ports                              direction  handshake
//   request   start, busy, req_data              in         start & !busy
//   response  rsp_valid, rsp_data                out        one-cycle strobe
//   config    csr_write_en, csr_index, csr_wdata in         write enable
//
// Free, mark and query pass through ST_LOOK to the registered response beat; an
// allocate stays in ST_LOOK, one bitmap word per cycle through the RAM read port.
// An allocate that cannot succeed from the start is answered in the next cycle.
// Reset clears the valid bit of every word at once, so no clearing pass is needed.
// The response beat cannot be stalled; busy stays high until it is issued.
module bitmap_page_frame_allocator #(
   parameter int MAX_PAGES = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  bpfa_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output bpfa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpfa_pkg::CSR_W-1:0]           csr_wdata
);

   import bpfa_pkg::*;

   localparam int DEPTH  = MAX_PAGES / WORD_BITS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LOG_WB = $clog2(WORD_BITS);
   localparam int PW     = AW + LOG_WB;
   localparam int CMP_W  = ($clog2(MAX_PAGES) + 1 > MANAGED_W) ?
                           $clog2(MAX_PAGES) + 1 : MANAGED_W;

   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [AW-1:0]          word_ff, word_in;
   logic [DEPTH-1:0]       valid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [MANAGED_W-1:0]   managed_ff;
   logic [RESERVED_W-1:0]  reserved_ff;

   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [WORD_BITS-1:0]   rd_data;
   logic                   wr_en;
   logic [WORD_BITS-1:0]   wr_data;

   logic [CMP_W-1:0]       limit;
   logic [CMP_W-1:0]       res_word;
   logic [CMP_W-1:0]       lim_word;
   logic [CMP_W-1:0]       last_word;
   logic [CMP_W-1:0]       word_ext;
   logic [WORD_BITS-1:0]   word_data;
   logic [WORD_BITS-1:0]   res_mask;
   logic [WORD_BITS-1:0]   lim_mask;
   logic [WORD_BITS-1:0]   free_bits;
   logic [WORD_BITS-1:0]   first_free;
   logic [LOG_WB-1:0]      free_idx;
   logic                   found;
   logic [PW-1:0]          found_page;
   logic [WORD_BITS-1:0]   page_sel;
   logic                   above_lim;
   logic                   below_res;
   logic                   raw_bit;
   logic                   eff_bit;
   logic                   accept;
   logic                   alloc_hopeless;

   bpfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(DEPTH)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(word_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign limit  = (CMP_W'(managed_ff) < CMP_W'(MAX_PAGES)) ? CMP_W'(managed_ff)
                                                           : CMP_W'(MAX_PAGES);
   assign alloc_hopeless = CMP_W'(reserved_ff) >= limit;

   assign res_word  = CMP_W'(reserved_ff) >> LOG_WB;
   assign lim_word  = limit >> LOG_WB;
   assign last_word = (limit - CMP_W'(1)) >> LOG_WB;
   assign word_ext  = CMP_W'(word_ff);
   assign word_data = valid_ff[word_ff] ? rd_data : '0;

   assign res_mask = (word_ext == res_word) ?
                     ~({WORD_BITS{1'b1}} << reserved_ff[LOG_WB-1:0]) : '0;
   assign lim_mask = (word_ext == lim_word) ?
                     ({WORD_BITS{1'b1}} << limit[LOG_WB-1:0]) : '0;
   assign free_bits  = ~(word_data | res_mask | lim_mask);
   assign first_free = free_bits & (~free_bits + WORD_BITS'(1));
   assign found      = |free_bits;

   always_comb begin
      free_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (first_free[b]) begin
            free_idx = free_idx | LOG_WB'(b);
         end
      end
   end

   assign found_page = {word_ff, free_idx};
   assign page_sel   = WORD_BITS'(1) << page_ff[LOG_WB-1:0];
   assign above_lim  = CMP_W'(page_ff) >= limit;
   assign below_res  = page_ff < reserved_ff;
   assign raw_bit    = word_data[page_ff[LOG_WB-1:0]];
   assign eff_bit    = above_lim ? 1'b0 : (below_res ? 1'b1 : raw_bit);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      page_in      = page_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_data      = word_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_data.operation;
               page_in = req_data.page;
               if (req_data.operation == OP_ALLOC) begin
                  word_in = AW'(reserved_ff >> LOG_WB);
               end else begin
                  word_in = AW'(req_data.page >> LOG_WB);
               end
               if ((req_data.operation == OP_ALLOC) && alloc_hopeless) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.page_out = '0;
                  rsp_data_in.status   = STATUS_NO_FREE;
                  rsp_data_in.in_use   = 1'b0;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = word_in;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (found) begin
                     wr_en                = 1'b1;
                     wr_data              = word_data | first_free;
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.page_out = PAGE_W'(found_page);
                     rsp_data_in.status   = STATUS_OK;
                     rsp_data_in.in_use   = 1'b1;
                     state_in             = ST_IDLE;
                  end else if (word_ext >= last_word) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.page_out = '0;
                     rsp_data_in.status   = STATUS_NO_FREE;
                     rsp_data_in.in_use   = 1'b0;
                     state_in             = ST_IDLE;
                  end else begin
                     word_in = word_ff + AW'(1);
                     rd_en   = 1'b1;
                     rd_addr = word_in;
                  end
               end
               OP_FREE, OP_MARK: begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.page_out = page_ff;
                  state_in             = ST_IDLE;
                  if (above_lim || below_res) begin
                     rsp_data_in.status = STATUS_BAD;
                     rsp_data_in.in_use = eff_bit;
                  end else begin
                     wr_en              = 1'b1;
                     wr_data            = (op_ff == OP_MARK) ? (word_data | page_sel)
                                                             : (word_data & ~page_sel);
                     rsp_data_in.status = STATUS_OK;
                     rsp_data_in.in_use = (op_ff == OP_MARK);
                  end
               end
               OP_QUERY: begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.page_out = page_ff;
                  rsp_data_in.status   = above_lim ? STATUS_BAD : STATUS_OK;
                  rsp_data_in.in_use   = eff_bit;
                  state_in             = ST_IDLE;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         managed_ff   <= MANAGED_RESET;
         reserved_ff  <= RESERVED_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[word_ff] <= 1'b1;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MANAGED:  managed_ff  <= csr_wdata;
               CSR_RESERVED: reserved_ff <= csr_wdata[RESERVED_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      page_ff     <= page_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept) || $past(state_ff == ST_LOOK)))
      else $error("response beat without a request behind it");

   a_write_in_look: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_LOOK) && rsp_valid_in)
      else $error("bitmap written outside the final lookup cycle");

   a_no_free_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_NO_FREE)) |->
         ((rsp_data.page_out == '0) && !rsp_data.in_use))
      else $error("failed allocate beat carries a page");

endmodule

// ----- hw/rtl/bpfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
